### hw/rtl/gasc_pkg.sv
// ============================================================================
// gasc_pkg
// Shared types and codes for the glyph atlas shelf cache.
// ============================================================================
package gasc_pkg;

    // Default number of table cells.
    localparam int TABLE_DEPTH = 256;

    // Field widths.
    localparam int CODE_W = 21;
    localparam int DIM_W  = 8;
    localparam int POS_W  = 12;
    localparam int CUR_W  = 13;

    // Cursor saturation value.
    localparam logic [CUR_W-1:0] CURSOR_MAX = 13'h1FFF;

    // Command codes.
    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_ADD    = 1'b1;

    // Result status codes.
    localparam logic [2:0] STAT_HIT     = 3'd0;
    localparam logic [2:0] STAT_MISS    = 3'd1;
    localparam logic [2:0] STAT_PRESENT = 3'd2;
    localparam logic [2:0] STAT_PLACED  = 3'd3;
    localparam logic [2:0] STAT_AFULL   = 3'd4;
    localparam logic [2:0] STAT_TFULL   = 3'd5;

    // Configuration register indexes.
    localparam logic [1:0] CFG_ATLAS_W = 2'd0;
    localparam logic [1:0] CFG_ATLAS_H = 2'd1;
    localparam logic [1:0] CFG_ROW_H   = 2'd2;

    // One stored glyph placement.
    typedef struct packed {
        logic signed [DIM_W-1:0] left;
        logic [DIM_W-1:0]        h;
        logic [DIM_W-1:0]        w;
        logic [POS_W-1:0]        y;
        logic [POS_W-1:0]        x;
    } entry_t;

    // Match bus that travels toward the head of the chain.
    typedef struct packed {
        logic   hit;
        entry_t entry;
    } bus_t;

    // Broadcast control from the sequencer to every cell.
    typedef struct packed {
        logic [CODE_W-1:0] code;
        entry_t            new_entry;
        logic              insert;
        logic              collect;
    } cell_ctrl_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DECIDE,
        ST_INSERT
    } state_t;

endpackage

### hw/rtl/glyph_atlas_shelf_cache_unit.sv
// ============================================================================
// glyph_atlas_shelf_cache_unit
// Sorted glyph table in a chain of cells with shelf packing placement.
// ============================================================================
// Sequence: a start transfer moves the sequencer from idle to search, where the
// match relay crosses the whole cell chain one cell per cycle; the decide
// state then sets done, which is registered together with the result.
// A new command is taken only in the idle state; a placed glyph adds an
// insert state in which the chain shifts before the return to idle.
// The receiver cannot stall; each result is shown for one cycle with done.
// Reset clears the fill count, cursor and control state and loads the
// default atlas settings.
module glyph_atlas_shelf_cache_unit #(
    parameter int TableDepth = gasc_pkg::TABLE_DEPTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              cmd,
    input  logic [gasc_pkg::CODE_W-1:0]       char_code,
    input  logic [gasc_pkg::DIM_W-1:0]        glyph_width,
    input  logic [gasc_pkg::DIM_W-1:0]        glyph_height,
    input  logic signed [gasc_pkg::DIM_W-1:0] glyph_left,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [1:0]                        cfg_index,
    input  logic [gasc_pkg::CUR_W-1:0]        cfg_data,
    output logic                              done,
    output logic [2:0]                        status,
    output logic [gasc_pkg::POS_W-1:0]        pos_x,
    output logic [gasc_pkg::POS_W-1:0]        pos_y,
    output logic [gasc_pkg::DIM_W-1:0]        rect_width,
    output logic [gasc_pkg::DIM_W-1:0]        rect_height,
    output logic signed [gasc_pkg::DIM_W-1:0] left_bearing
);

    localparam int CntW = $clog2(TableDepth + 1);
    localparam int SchW = $clog2(TableDepth);
    localparam int CurW = gasc_pkg::CUR_W;

    gasc_pkg::state_t              state_reg, state_next;
    logic [SchW-1:0]               sch_reg, sch_next;
    logic [CntW-1:0]               count_reg, count_next;
    logic [CurW-1:0]               cx_reg, cx_next;
    logic [CurW-1:0]               cy_reg, cy_next;
    logic [CurW-1:0]               aw_reg, ah_reg;
    logic [gasc_pkg::DIM_W-1:0]    rh_reg;
    logic                          cmd_reg;
    logic [gasc_pkg::CODE_W-1:0]   code_reg;
    logic [gasc_pkg::DIM_W-1:0]    w_reg, h_reg;
    logic [gasc_pkg::DIM_W-1:0]    left_reg;
    gasc_pkg::entry_t              new_reg, new_next;
    logic                          done_reg, done_next;
    logic [2:0]                    status_reg, status_next;
    gasc_pkg::entry_t              res_reg, res_next;

    gasc_pkg::cell_ctrl_t          ctrl;
    logic                          lt_w [TableDepth];
    logic [gasc_pkg::CODE_W-1:0]   key_w [TableDepth];
    gasc_pkg::entry_t              entry_w [TableDepth];
    gasc_pkg::bus_t                bus_w [TableDepth];

    logic                          found;
    logic [CurW:0]                 sum_x, row_y, vert, nx;
    logic                          overflow, vfail;
    logic [CurW-1:0]               ny_sat, cy_new, cx_base, cx_after;

    // Configuration port is always ready.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            aw_reg <= 13'd1024;
            ah_reg <= 13'd1024;
            rh_reg <= 8'd32;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                gasc_pkg::CFG_ATLAS_W: aw_reg <= cfg_data;
                gasc_pkg::CFG_ATLAS_H: ah_reg <= cfg_data;
                gasc_pkg::CFG_ROW_H:   rh_reg <= cfg_data[gasc_pkg::DIM_W-1:0];
                default:               ;
            endcase
        end
    end

    // Command capture on the start transfer.
    always_ff @(posedge clk)
    begin
        if (start && (state_reg == gasc_pkg::ST_IDLE))
        begin
            cmd_reg  <= cmd;
            code_reg <= char_code;
            w_reg    <= glyph_width;
            h_reg    <= glyph_height;
            left_reg <= glyph_left;
        end
    end

    // Broadcast control to the cells.
    assign ctrl.code      = code_reg;
    assign ctrl.new_entry = new_reg;
    assign ctrl.insert    = state_reg == gasc_pkg::ST_INSERT;
    assign ctrl.collect   = state_reg == gasc_pkg::ST_SEARCH;

    // The chain of table cells.
    for (genvar i = 0; i < TableDepth; i++)
    begin : g_cell
        logic                        l_lt;
        logic [gasc_pkg::CODE_W-1:0] l_key;
        gasc_pkg::entry_t            l_entry;
        gasc_pkg::bus_t              r_bus;

        if (i == 0)
        begin : g_head
            assign l_lt    = 1'b1;
            assign l_key   = '0;
            assign l_entry = '0;
        end
        else
        begin : g_body
            assign l_lt    = lt_w[i-1];
            assign l_key   = key_w[i-1];
            assign l_entry = entry_w[i-1];
        end

        if (i == TableDepth - 1)
        begin : g_tail
            assign r_bus = '0;
        end
        else
        begin : g_link
            assign r_bus = bus_w[i+1];
        end

        gasc_cell #(
            .TableDepth(TableDepth),
            .Idx       (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .count     (count_reg),
            .left_lt   (l_lt),
            .left_key  (l_key),
            .left_entry(l_entry),
            .bus_in    (r_bus),
            .lt        (lt_w[i]),
            .key       (key_w[i]),
            .entry     (entry_w[i]),
            .bus_out   (bus_w[i])
        );
    end

    // Shelf placement arithmetic.
    assign found    = bus_w[0].hit;
    assign sum_x    = {1'b0, cx_reg} + {6'd0, w_reg};
    assign overflow = sum_x > {1'b0, aw_reg};
    assign row_y    = {1'b0, cy_reg} + {6'd0, rh_reg};
    assign ny_sat   = row_y[CurW] ? gasc_pkg::CURSOR_MAX : row_y[CurW-1:0];
    assign cy_new   = overflow ? ny_sat : cy_reg;
    assign cx_base  = overflow ? '0 : cx_reg;
    assign nx       = overflow ? {6'd0, w_reg} : sum_x;
    assign vert     = {1'b0, cy_new} + {6'd0, h_reg};
    assign vfail    = vert > {1'b0, ah_reg};
    assign cx_after = nx[CurW] ? gasc_pkg::CURSOR_MAX : nx[CurW-1:0];

    // Sequencer next state and result.
    always_comb
    begin
        state_next  = state_reg;
        sch_next    = sch_reg;
        count_next  = count_reg;
        cx_next     = cx_reg;
        cy_next     = cy_reg;
        new_next    = new_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        res_next    = res_reg;
        case (state_reg)
            gasc_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    sch_next   = '0;
                    state_next = gasc_pkg::ST_SEARCH;
                end
            end
            gasc_pkg::ST_SEARCH:
            begin
                sch_next = sch_reg + 1'b1;
                if (sch_reg == SchW'(TableDepth - 1))
                begin
                    state_next = gasc_pkg::ST_DECIDE;
                end
            end
            gasc_pkg::ST_DECIDE:
            begin
                done_next  = 1'b1;
                res_next   = '0;
                state_next = gasc_pkg::ST_IDLE;
                if (cmd_reg == gasc_pkg::CMD_LOOKUP)
                begin
                    status_next = found ? gasc_pkg::STAT_HIT : gasc_pkg::STAT_MISS;
                    if (found)
                    begin
                        res_next = bus_w[0].entry;
                    end
                end
                else if (found)
                begin
                    status_next = gasc_pkg::STAT_PRESENT;
                end
                else if (count_reg == CntW'(TableDepth))
                begin
                    status_next = gasc_pkg::STAT_TFULL;
                end
                else
                begin
                    cy_next = cy_new;
                    cx_next = cx_base;
                    if (vfail)
                    begin
                        status_next = gasc_pkg::STAT_AFULL;
                    end
                    else
                    begin
                        cx_next        = cx_after;
                        new_next.x     = cx_base[gasc_pkg::POS_W-1:0];
                        new_next.y     = cy_new[gasc_pkg::POS_W-1:0];
                        new_next.w     = w_reg;
                        new_next.h     = h_reg;
                        new_next.left  = left_reg;
                        res_next       = new_next;
                        status_next    = gasc_pkg::STAT_PLACED;
                        state_next     = gasc_pkg::ST_INSERT;
                    end
                end
            end
            gasc_pkg::ST_INSERT:
            begin
                count_next = count_reg + 1'b1;
                state_next = gasc_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = gasc_pkg::ST_IDLE;
            end
        endcase
    end

    // Control and cursor registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= gasc_pkg::ST_IDLE;
            sch_reg    <= '0;
            count_reg  <= '0;
            cx_reg     <= '0;
            cy_reg     <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            sch_reg    <= sch_next;
            count_reg  <= count_next;
            cx_reg     <= cx_next;
            cy_reg     <= cy_next;
            done_reg   <= done_next;
        end
    end

    // Result payload registers.
    always_ff @(posedge clk)
    begin
        new_reg    <= new_next;
        status_reg <= status_next;
        res_reg    <= res_next;
    end

    assign busy         = state_reg != gasc_pkg::ST_IDLE;
    assign done         = done_reg;
    assign status       = status_reg;
    assign pos_x        = res_reg.x;
    assign pos_y        = res_reg.y;
    assign rect_width   = res_reg.w;
    assign rect_height  = res_reg.h;
    assign left_bearing = res_reg.left;

    // The fill count never passes the table depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CntW'(TableDepth))
        else $error("fill count beyond table depth");

    // A result follows the decision cycle only.
    a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == gasc_pkg::ST_DECIDE))
        else $error("result without decision");

    // The chain shifts only for a placed glyph.
    a_insert_placed: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == gasc_pkg::ST_INSERT) |-> (done && status == gasc_pkg::STAT_PLACED))
        else $error("insert without placement");

    // The fill count moves only out of the insert cycle.
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> $past(state_reg == gasc_pkg::ST_INSERT))
        else $error("fill count changed outside insert");

endmodule

### hw/rtl/gasc_cell.sv
// ============================================================================
// gasc_cell
// One slot of the sorted table: holds a key and entry, compares against the
// broadcast code, shifts right on insert and relays matches toward the head.
// ============================================================================
module gasc_cell #(
    parameter int TableDepth = gasc_pkg::TABLE_DEPTH,
    parameter int Idx        = 0
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  gasc_pkg::cell_ctrl_t        ctrl,
    input  logic [$clog2(TableDepth+1)-1:0] count,
    input  logic                        left_lt,
    input  logic [gasc_pkg::CODE_W-1:0] left_key,
    input  gasc_pkg::entry_t            left_entry,
    input  gasc_pkg::bus_t              bus_in,
    output logic                        lt,
    output logic [gasc_pkg::CODE_W-1:0] key,
    output gasc_pkg::entry_t            entry,
    output gasc_pkg::bus_t              bus_out
);

    localparam int CntW = $clog2(TableDepth + 1);

    logic [gasc_pkg::CODE_W-1:0] key_reg;
    gasc_pkg::entry_t            entry_reg;
    gasc_pkg::bus_t              bus_reg;
    logic                        occupied;
    logic                        eq;

    // The cell holds a live entry when its place is below the fill count.
    assign occupied = CntW'(Idx) < count;
    assign lt       = occupied && (key_reg < ctrl.code);
    assign eq       = occupied && (key_reg == ctrl.code);

    // Shift insert: the slot takes the new entry and cells past it take their left neighbor.
    always_ff @(posedge clk)
    begin
        if (ctrl.insert && !lt)
        begin
            if (left_lt)
            begin
                key_reg   <= ctrl.code;
                entry_reg <= ctrl.new_entry;
            end
            else
            begin
                key_reg   <= left_key;
                entry_reg <= left_entry;
            end
        end
    end

    // Match relay: a hit here replaces what arrives from the right.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bus_reg <= '0;
        end
        else if (ctrl.collect)
        begin
            if (eq)
            begin
                bus_reg <= {1'b1, entry_reg};
            end
            else
            begin
                bus_reg <= bus_in;
            end
        end
    end

    assign key     = key_reg;
    assign entry   = entry_reg;
    assign bus_out = bus_reg;

endmodule
